/* sv/pgrav_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pgrav_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int AGE_W     = FRAC_BITS + 1;
  localparam int Q1_W      = 48;
  localparam int Q2_W      = 32;
  localparam int SQ_STAGES = 32;

  localparam logic [63:0] NEAR_R2 =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;

  typedef logic [AGE_W-1:0] age_t;
  localparam age_t AGE_ONE = age_t'(1) << FRAC_BITS;

  typedef logic signed [31:0] fix_t;
  localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN = 32'sh8000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTRE_X       = 3'd0,
    REG_CENTRE_Y       = 3'd1,
    REG_CENTRE_Z       = 3'd2,
    REG_SOURCE_RADIUS  = 3'd3,
    REG_SOURCE_GM      = 3'd4,
    REG_LINEAR_FALLOFF = 3'd5,
    REG_AXIS_MASK      = 3'd6,
    REG_GRAVITY_ENABLE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    fix_t [2:0]  centre;
    logic [31:0] radius;
    logic [31:0] gm;
    logic        linear;
    logic [2:0]  axis_mask;
    logic        grav_en;
  } cfg_t;

  // particle state travelling down the pipeline
  typedef struct packed {
    fix_t [2:0] loc;
    fix_t [2:0] vel;
    fix_t [2:0] acc;
    age_t       step;
    age_t       new_age;
    logic       alive;
    logic [2:0] grav;
    logic [2:0] neg;
    logic       in_rad;
  } item_t;

  // square root and first divide working set
  typedef struct packed {
    logic [63:0]           c1;
    logic [2:0][63:0]      rem;
    logic [2:0][Q1_W-1:0]  num;
    logic [2:0]            ovf;
    logic [63:0]           sx;
    logic [33:0]           srem;
    logic [31:0]           root;
  } sd_t;

  // second divide working set
  typedef struct packed {
    logic [31:0]           c2;
    logic [2:0][31:0]      rem;
    logic [2:0][Q2_W-1:0]  num;
    logic [2:0]            ovf2;
    logic [2:0]            big1;
    logic [2:0][30:0]      q1lo;
  } d2_t;

  // saturate a 34 bit two's complement value to 32 bits
  function automatic fix_t sat32(input logic [33:0] v);
    fix_t r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = FIX_MIN;
    end else begin
      r = FIX_MAX;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/pgrav_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pgrav_particle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] loc_x;
  logic signed [31:0] loc_y;
  logic signed [31:0] loc_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_z;
  logic [16:0]        age;
  logic [31:0]        age_rate;
  logic [16:0]        substep;

  modport source (
    output valid, loc_x, loc_y, loc_z, vel_x, vel_y, vel_z,
           acc_x, acc_y, acc_z, age, age_rate, substep,
    input  ready
  );
  modport sink (
    input  valid, loc_x, loc_y, loc_z, vel_x, vel_y, vel_z,
           acc_x, acc_y, acc_z, age, age_rate, substep,
    output ready
  );
endinterface

interface pgrav_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_loc_x;
  logic signed [31:0] new_loc_y;
  logic signed [31:0] new_loc_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic signed [31:0] new_acc_x;
  logic signed [31:0] new_acc_y;
  logic signed [31:0] new_acc_z;
  logic [16:0]        new_age;
  logic               alive;

  modport source (
    output valid, new_loc_x, new_loc_y, new_loc_z, new_vel_x, new_vel_y,
           new_vel_z, new_acc_x, new_acc_y, new_acc_z, new_age, alive,
    input  ready
  );
  modport sink (
    input  valid, new_loc_x, new_loc_y, new_loc_z, new_vel_x, new_vel_y,
           new_vel_z, new_acc_x, new_acc_y, new_acc_z, new_age, alive,
    output ready
  );
endinterface
`default_nettype wire

/* sv/pgrav_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module pgrav_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  pgrav_pkg::item_t in_item,
  input  pgrav_pkg::age_t  in_age,
  input  logic [31:0]      in_rate,
  input  pgrav_pkg::cfg_t  cfg,
  output logic             out_v,
  output pgrav_pkg::item_t out_item,
  output pgrav_pkg::sd_t   out_sd
);
  import pgrav_pkg::*;

  // stage 1: age product, offset to centre
  logic             f1_v;
  item_t            f1_item;
  age_t             f1_age;
  logic [48:0]      f1_prod;
  logic [2:0][31:0] f1_mag;
  logic [2:0]       f1_neg;
  fix_t [2:0]       d_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_c[j] = sat32(34'($signed(cfg.centre[j])) - 34'($signed(in_item.loc[j])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_item <= in_item;
      f1_age  <= in_age;
      f1_prod <= in_item.step * in_rate;
      for (int j = 0; j < 3; j++) begin
        f1_neg[j] <= d_c[j][31];
        f1_mag[j] <= d_c[j][31] ? 32'(-d_c[j]) : 32'(d_c[j]);
      end
    end
  end

  // stage 2: age update and death test, squares, source radius squared
  logic             f2_v;
  item_t            f2_item;
  item_t            f2_item_next;
  logic [2:0][63:0] f2_sq;
  logic [2:0][31:0] f2_mag;
  logic [63:0]      f2_bigr2;
  logic [33:0]      age_sum;
  logic             alive_c;

  assign age_sum = 34'(f1_age) + 34'(f1_prod[48:FRAC_BITS]);
  assign alive_c = age_sum <= 34'(AGE_ONE);

  always_comb begin
    f2_item_next         = f1_item;
    f2_item_next.alive   = alive_c;
    f2_item_next.new_age = alive_c ? age_sum[AGE_W-1:0] : AGE_ONE;
    f2_item_next.neg     = f1_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (en) begin
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_item  <= f2_item_next;
      f2_bigr2 <= cfg.radius * cfg.radius;
      f2_mag   <= f1_mag;
      for (int j = 0; j < 3; j++) begin
        f2_sq[j] <= f1_mag[j] * f1_mag[j];
      end
    end
  end

  // stage 3: distance squared and force numerators
  logic             f3_v;
  item_t            f3_item;
  logic [63:0]      f3_r2;
  logic [63:0]      f3_bigr2;
  logic [2:0][63:0] f3_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_v <= 1'b0;
    end else if (en) begin
      f3_v <= f2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_item  <= f2_item;
      f3_r2    <= f2_sq[0] + f2_sq[1] + f2_sq[2];
      f3_bigr2 <= f2_bigr2;
      for (int j = 0; j < 3; j++) begin
        f3_p[j] <= cfg.gm * f2_mag[j];
      end
    end
  end

  // stage 4: inside test, divisor choice, divider and root set-up
  logic        near_c;
  logic        in_rad_c;
  logic [63:0] c1_c;
  item_t       out_item_next;

  assign near_c   = f3_r2 < NEAR_R2;
  assign in_rad_c = f3_r2 < f3_bigr2;
  assign c1_c     = in_rad_c ? f3_bigr2 : f3_r2;

  always_comb begin
    out_item_next        = f3_item;
    out_item_next.in_rad = in_rad_c;
    for (int j = 0; j < 3; j++) begin
      out_item_next.grav[j] = f3_item.alive & cfg.grav_en & cfg.axis_mask[j] & ~near_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= f3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item    <= out_item_next;
      out_sd.c1   <= c1_c;
      out_sd.sx   <= f3_r2;
      out_sd.srem <= '0;
      out_sd.root <= '0;
      for (int j = 0; j < 3; j++) begin
        out_sd.rem[j] <= {32'd0, f3_p[j][63:32]};
        out_sd.num[j] <= {f3_p[j][31:0], {FRAC_BITS{1'b0}}};
        out_sd.ovf[j] <= {32'd0, f3_p[j][63:32]} >= c1_c;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/pgrav_sqdiv.sv */
`timescale 1ns / 1ps
`default_nettype none
module pgrav_sqdiv (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  pgrav_pkg::item_t in_item,
  input  pgrav_pkg::sd_t   in_sd,
  output logic             out_v,
  output pgrav_pkg::item_t out_item,
  output pgrav_pkg::sd_t   out_sd
);
  import pgrav_pkg::*;

  localparam int SD_STAGES = Q1_W;

  // one quotient bit per lane, and one root bit while the root is open
  function automatic sd_t sd_step(input sd_t s, input logic do_sq);
    sd_t         n;
    logic [64:0] t;
    logic [64:0] dif;
    logic [35:0] st;
    logic [35:0] trial;
    logic [35:0] sdif;
    n = s;
    for (int j = 0; j < 3; j++) begin
      t   = {s.rem[j], s.num[j][Q1_W-1]};
      dif = t - {1'b0, s.c1};
      if (t >= {1'b0, s.c1}) begin
        n.rem[j] = dif[63:0];
        n.num[j] = {s.num[j][Q1_W-2:0], 1'b1};
      end else begin
        n.rem[j] = t[63:0];
        n.num[j] = {s.num[j][Q1_W-2:0], 1'b0};
      end
    end
    if (do_sq) begin
      st    = {s.srem, s.sx[63:62]};
      trial = {2'b00, s.root, 2'b01};
      sdif  = st - trial;
      n.sx  = {s.sx[61:0], 2'b00};
      if (st >= trial) begin
        n.srem = sdif[33:0];
        n.root = {s.root[30:0], 1'b1};
      end else begin
        n.srem = st[33:0];
        n.root = {s.root[30:0], 1'b0};
      end
    end
    return n;
  endfunction

  logic  vv [SD_STAGES];
  sd_t   st [SD_STAGES];
  item_t it [SD_STAGES];

  for (genvar k = 0; k < SD_STAGES; k++) begin : g_stage
    logic  pv;
    sd_t   ps;
    item_t pi;
    if (k == 0) begin : g_first
      assign pv = in_v;
      assign ps = in_sd;
      assign pi = in_item;
    end else begin : g_next
      assign pv = vv[k-1];
      assign ps = st[k-1];
      assign pi = it[k-1];
    end

    // valid bit per stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k] <= 1'b0;
      end else if (en) begin
        vv[k] <= pv;
      end
    end

    // working set
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= sd_step(ps, k < SQ_STAGES);
        it[k] <= pi;
      end
    end
  end

  assign out_v    = vv[SD_STAGES-1];
  assign out_sd   = st[SD_STAGES-1];
  assign out_item = it[SD_STAGES-1];

endmodule
`default_nettype wire

/* sv/pgrav_div2.sv */
`timescale 1ns / 1ps
`default_nettype none
module pgrav_div2 (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  pgrav_pkg::item_t in_item,
  input  pgrav_pkg::sd_t   in_sd,
  input  pgrav_pkg::cfg_t  cfg,
  output logic             out_v,
  output pgrav_pkg::item_t out_item,
  output pgrav_pkg::d2_t   out_d2
);
  import pgrav_pkg::*;

  // first quotient saturates to all ones, second divisor is R inside, r outside
  function automatic d2_t d2_setup(input sd_t s, input logic in_rad,
                                   input logic [31:0] radius);
    d2_t             n;
    logic [Q1_W-1:0] q1;
    n    = '0;
    n.c2 = in_rad ? radius : s.root;
    for (int j = 0; j < 3; j++) begin
      q1         = s.ovf[j] ? '1 : s.num[j];
      n.ovf2[j]  = q1[Q1_W-1:FRAC_BITS] >= n.c2;
      n.rem[j]   = q1[Q1_W-1:FRAC_BITS];
      n.num[j]   = {q1[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      n.big1[j]  = s.ovf[j] | (q1[Q1_W-1:31] != '0);
      n.q1lo[j]  = q1[30:0];
    end
    return n;
  endfunction

  function automatic d2_t d2_step(input d2_t s);
    d2_t         n;
    logic [32:0] t;
    logic [32:0] dif;
    n = s;
    for (int j = 0; j < 3; j++) begin
      t   = {s.rem[j], s.num[j][Q2_W-1]};
      dif = t - {1'b0, s.c2};
      if (t >= {1'b0, s.c2}) begin
        n.rem[j] = dif[31:0];
        n.num[j] = {s.num[j][Q2_W-2:0], 1'b1};
      end else begin
        n.rem[j] = t[31:0];
        n.num[j] = {s.num[j][Q2_W-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  // set-up stage
  logic  s0_v;
  d2_t   s0_d;
  item_t s0_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d    <= d2_setup(in_sd, in_item.in_rad, cfg.radius);
      s0_item <= in_item;
    end
  end

  // one quotient bit per stage
  logic  vv [Q2_W];
  d2_t   st [Q2_W];
  item_t it [Q2_W];

  for (genvar k = 0; k < Q2_W; k++) begin : g_stage
    logic  pv;
    d2_t   ps;
    item_t pi;
    if (k == 0) begin : g_first
      assign pv = s0_v;
      assign ps = s0_d;
      assign pi = s0_item;
    end else begin : g_next
      assign pv = vv[k-1];
      assign ps = st[k-1];
      assign pi = it[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k] <= 1'b0;
      end else if (en) begin
        vv[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= d2_step(ps);
        it[k] <= pi;
      end
    end
  end

  assign out_v    = vv[Q2_W-1];
  assign out_d2   = st[Q2_W-1];
  assign out_item = it[Q2_W-1];

endmodule
`default_nettype wire

/* sv/pgrav_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module pgrav_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  pgrav_pkg::item_t in_item,
  input  pgrav_pkg::d2_t   in_d2,
  input  pgrav_pkg::cfg_t  cfg,
  output logic             out_v,
  output pgrav_pkg::item_t out_item
);
  import pgrav_pkg::*;

  // stage 1: signed, saturated gravity on the selected axes
  logic       b1_v;
  item_t      b1_item;
  item_t      b1_item_next;
  fix_t [2:0] acc_c;

  always_comb begin
    logic        big;
    logic [30:0] m;
    for (int j = 0; j < 3; j++) begin
      big = cfg.linear ? in_d2.big1[j] : (in_d2.ovf2[j] | in_d2.num[j][31]);
      m   = cfg.linear ? in_d2.q1lo[j] : in_d2.num[j][30:0];
      if (!in_item.grav[j]) begin
        acc_c[j] = in_item.acc[j];
      end else if (big) begin
        acc_c[j] = in_item.neg[j] ? FIX_MIN : FIX_MAX;
      end else begin
        acc_c[j] = in_item.neg[j] ? -{1'b0, m} : {1'b0, m};
      end
    end
  end

  always_comb begin
    b1_item_next     = in_item;
    b1_item_next.acc = acc_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (en) begin
      b1_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_item <= b1_item_next;
    end
  end

  // stage 2: velocity increment product
  logic                    b2_v;
  item_t                   b2_item;
  logic signed [2:0][49:0] b2_av;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else if (en) begin
      b2_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_item <= b1_item;
      for (int j = 0; j < 3; j++) begin
        b2_av[j] <= $signed(b1_item.acc[j]) * $signed({1'b0, b1_item.step});
      end
    end
  end

  // stage 3: new velocity
  logic  b3_v;
  item_t b3_item;
  item_t b3_item_next;

  always_comb begin
    b3_item_next = b2_item;
    for (int j = 0; j < 3; j++) begin
      if (b2_item.alive) begin
        b3_item_next.vel[j] = sat32(34'($signed(b2_item.vel[j]))
                                    + $signed(b2_av[j][49:FRAC_BITS]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_v <= 1'b0;
    end else if (en) begin
      b3_v <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_item <= b3_item_next;
    end
  end

  // stage 4: location increment product
  logic                    b4_v;
  item_t                   b4_item;
  logic signed [2:0][49:0] b4_lv;

  always_ff @(posedge clk) begin
    if (rst) begin
      b4_v <= 1'b0;
    end else if (en) begin
      b4_v <= b3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b4_item <= b3_item;
      for (int j = 0; j < 3; j++) begin
        b4_lv[j] <= $signed(b3_item.vel[j]) * $signed({1'b0, b3_item.step});
      end
    end
  end

  // stage 5: new location
  item_t out_item_next;

  always_comb begin
    out_item_next = b4_item;
    for (int j = 0; j < 3; j++) begin
      if (b4_item.alive) begin
        out_item_next.loc[j] = sat32(34'($signed(b4_item.loc[j]))
                                     + $signed(b4_lv[j][49:FRAC_BITS]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= b4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= out_item_next;
    end
  end

endmodule
`default_nettype wire

/* sv/particle_gravity_euler_step_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Point gravity particle step, Q16.16.
// Particles enter on the particle channel (valid/ready), one transaction per
// particle; updated location, velocity, acceleration, age and the alive flag
// leave on the result channel, one transaction per particle, in order.
// The attractor is set up through the write port (wr_en, wr_index, wr_data).
// The user must do so only while no particle is in flight; the block itself
// does not enforce this. One particle is accepted per clock while ready is
// high. The pipeline runs through 4 front stages (age, offsets, squares,
// products), 48 stages of the first divider with the 32 step square root
// alongside, 33 stages of the second divider, 5 integration stages and the
// result register.
// Reset clears every valid bit and loads the register defaults (centre 0,
// radius 1.0, gm 0, squared falloff, all axes, gravity off).
// A stalled receiver is absorbed by the result register and one skid
// register; once the skid register is occupied, ready drops and the whole
// pipeline holds until the receiver takes the waiting result.
module particle_gravity_euler_step_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [2:0]                    wr_index,
  input  logic [31:0]                   wr_data,
  pgrav_particle_if.sink                particle,
  pgrav_result_if.source                result
);
  import pgrav_pkg::*;

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre    <= '0;
      cfg.radius    <= 32'd1 << FRAC_BITS;
      cfg.gm        <= '0;
      cfg.linear    <= 1'b0;
      cfg.axis_mask <= 3'b111;
      cfg.grav_en   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_CENTRE_X:       cfg.centre[0] <= wr_data;
        REG_CENTRE_Y:       cfg.centre[1] <= wr_data;
        REG_CENTRE_Z:       cfg.centre[2] <= wr_data;
        REG_SOURCE_RADIUS:  cfg.radius    <= wr_data;
        REG_SOURCE_GM:      cfg.gm        <= wr_data;
        REG_LINEAR_FALLOFF: cfg.linear    <= wr_data[0];
        REG_AXIS_MASK:      cfg.axis_mask <= wr_data[2:0];
        REG_GRAVITY_ENABLE: cfg.grav_en   <= wr_data[0];
        default: ;
      endcase
    end
  end

  // input unpacking
  item_t in_item;

  always_comb begin
    in_item        = '0;
    in_item.loc[0] = particle.loc_x;
    in_item.loc[1] = particle.loc_y;
    in_item.loc[2] = particle.loc_z;
    in_item.vel[0] = particle.vel_x;
    in_item.vel[1] = particle.vel_y;
    in_item.vel[2] = particle.vel_z;
    in_item.acc[0] = particle.acc_x;
    in_item.acc[1] = particle.acc_y;
    in_item.acc[2] = particle.acc_z;
    in_item.step   = particle.substep;
  end

  // pipeline
  logic  en;
  logic  fr_v, sd_v, d2_v, last_v;
  item_t fr_item, sd_item, d2_item, last_item;
  sd_t   fr_sd, sd_sd;
  d2_t   d2_d;

  pgrav_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (particle.valid),
    .in_item  (in_item),
    .in_age   (particle.age),
    .in_rate  (particle.age_rate),
    .cfg      (cfg),
    .out_v    (fr_v),
    .out_item (fr_item),
    .out_sd   (fr_sd)
  );

  pgrav_sqdiv u_sqdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (fr_v),
    .in_item  (fr_item),
    .in_sd    (fr_sd),
    .out_v    (sd_v),
    .out_item (sd_item),
    .out_sd   (sd_sd)
  );

  pgrav_div2 u_div2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (sd_v),
    .in_item  (sd_item),
    .in_sd    (sd_sd),
    .cfg      (cfg),
    .out_v    (d2_v),
    .out_item (d2_item),
    .out_d2   (d2_d)
  );

  pgrav_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (d2_v),
    .in_item  (d2_item),
    .in_d2    (d2_d),
    .cfg      (cfg),
    .out_v    (last_v),
    .out_item (last_item)
  );

  // result register with skid register
  logic  res_v, skid_v, res_fire;
  item_t res_q, skid_q;

  assign en             = ~skid_v;
  assign particle.ready = en;
  assign res_fire       = res_v & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (res_fire) begin
        skid_v <= 1'b0;
      end
    end else if (last_v) begin
      if (!res_v || res_fire) begin
        res_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (res_fire) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (res_fire) begin
        res_q <= skid_q;
      end
    end else if (last_v) begin
      if (!res_v || res_fire) begin
        res_q <= last_item;
      end else begin
        skid_q <= last_item;
      end
    end
  end

  // result channel
  assign result.valid     = res_v;
  assign result.new_loc_x = res_q.loc[0];
  assign result.new_loc_y = res_q.loc[1];
  assign result.new_loc_z = res_q.loc[2];
  assign result.new_vel_x = res_q.vel[0];
  assign result.new_vel_y = res_q.vel[1];
  assign result.new_vel_z = res_q.vel[2];
  assign result.new_acc_x = res_q.acc[0];
  assign result.new_acc_y = res_q.acc[1];
  assign result.new_acc_z = res_q.acc[2];
  assign result.new_age   = res_q.new_age;
  assign result.alive     = res_q.alive;

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import pgrav_pkg::*;

  typedef struct {
    logic signed [31:0] loc [3];
    logic signed [31:0] vel [3];
    logic signed [31:0] acc [3];
    logic [16:0]        age;
    logic [31:0]        age_rate;
    logic [16:0]        substep;
  } particle_t;

  typedef struct {
    logic signed [31:0] loc [3];
    logic signed [31:0] vel [3];
    logic signed [31:0] acc [3];
    logic [16:0]        age;
    logic               alive;
  } step_res_t;

  // expected particle updates and the attractor setup they are worked out with
  class pgrav_board;
    logic signed [31:0] centre [3];
    logic [31:0]        radius;
    logic [31:0]        gm;
    logic               linear;
    logic [2:0]         mask;
    logic               grav_en;
    step_res_t          expected_q [$];
    int                 mismatches;

    function new();
      centre[0] = 0; centre[1] = 0; centre[2] = 0;
      radius = 32'd65536; gm = 0; linear = 0; mask = 3'd7; grav_en = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_CENTRE_X:       centre[0] = v;
        REG_CENTRE_Y:       centre[1] = v;
        REG_CENTRE_Z:       centre[2] = v;
        REG_SOURCE_RADIUS:  radius = v;
        REG_SOURCE_GM:      gm = v;
        REG_LINEAR_FALLOFF: linear = v[0];
        REG_AXIS_MASK:      mask = v[2:0];
        REG_GRAVITY_ENABLE: grav_en = v[0];
        default: ;
      endcase
    endfunction

    function logic signed [63:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [63:0] root64(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // floor(a * 2^16 / c), saturated to 64 bits
    function logic [63:0] frac_div(logic [63:0] a, logic [63:0] c);
      logic [127:0] q;
      if (c == 0) return '1;
      q = {48'd0, a, 16'd0} / {64'd0, c};
      if (q[127:64] != 0) return '1;
      return q[63:0];
    endfunction

    function step_res_t advance(particle_t p);
      step_res_t          r;
      logic [63:0]        sum, r2, big_r2, root, mag, q;
      logic signed [63:0] d [3];
      logic signed [63:0] loc [3];
      logic signed [63:0] vel [3];
      logic signed [63:0] acc [3];
      logic signed [63:0] stp;
      logic               in_rad;
      sum = 64'(p.age) + ((64'(p.substep) * 64'(p.age_rate)) >> 16);
      stp = $signed({47'd0, p.substep});
      for (int j = 0; j < 3; j++) begin
        loc[j] = p.loc[j]; vel[j] = p.vel[j]; acc[j] = p.acc[j];
      end
      r.alive = (sum <= 64'd65536);
      if (r.alive) begin
        if (grav_en) begin
          r2 = 0;
          for (int j = 0; j < 3; j++) begin
            d[j] = clamp32(64'(centre[j]) - loc[j]);
            r2 = r2 + 64'(d[j] * d[j]);
          end
          if (r2 >= NEAR_R2) begin
            big_r2 = 64'(radius) * 64'(radius);
            root = root64(r2);
            in_rad = r2 < big_r2;
            for (int j = 0; j < 3; j++) begin
              if (mask[j]) begin
                mag = (d[j] < 0) ? 64'(-d[j]) : 64'(d[j]);
                if (in_rad) begin
                  q = frac_div(64'(gm) * mag, big_r2);
                  if (!linear) q = frac_div(q, 64'(radius));
                end else begin
                  q = frac_div(64'(gm) * mag, r2);
                  if (!linear) q = frac_div(q, root);
                end
                if (d[j] < 0) begin
                  acc[j] = (q >= 64'd2147483648) ? -64'sd2147483648 : -$signed(q);
                end else begin
                  acc[j] = (q > 64'd2147483647) ? 64'sd2147483647 : $signed(q);
                end
              end
            end
          end
        end
        for (int j = 0; j < 3; j++) vel[j] = clamp32(vel[j] + ((acc[j] * stp) >>> 16));
        for (int j = 0; j < 3; j++) loc[j] = clamp32(loc[j] + ((vel[j] * stp) >>> 16));
        r.age = sum[16:0];
      end else begin
        r.age = AGE_ONE;
      end
      for (int j = 0; j < 3; j++) begin
        r.loc[j] = loc[j][31:0]; r.vel[j] = vel[j][31:0]; r.acc[j] = acc[j][31:0];
      end
      return r;
    endfunction

    function void note_particle(particle_t p);
      expected_q.push_back(advance(p));
    endfunction

    function void check_result(step_res_t a);
      step_res_t   e;
      logic [31:0] ev [11];
      logic [31:0] av [11];
      string       names [11];
      bit          bad;
      names = '{"loc_x", "loc_y", "loc_z", "vel_x", "vel_y", "vel_z",
                "acc_x", "acc_y", "acc_z", "age", "alive"};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transaction with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      for (int j = 0; j < 3; j++) begin
        ev[j] = e.loc[j]; ev[3+j] = e.vel[j]; ev[6+j] = e.acc[j];
        av[j] = a.loc[j]; av[3+j] = a.vel[j]; av[6+j] = a.acc[j];
      end
      ev[9] = 32'(e.age); av[9] = 32'(a.age);
      ev[10] = 32'(e.alive); av[10] = 32'(a.alive);
      bad = 0;
      for (int k = 0; k < 11; k++) begin
        if (av[k] !== ev[k]) begin
          if (!bad) mismatches++;
          bad = 1;
          if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", names[k], ev[k], av[k]);
        end
      end
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        wr_en = 0;
  logic [2:0]  wr_index = '0;
  logic [31:0] wr_data = '0;
  bit          quiet = 0;
  bit          hold_req = 0;

  pgrav_particle_if particle_ch ();
  pgrav_result_if   result_ch ();

  pgrav_board board = new();

  particle_gravity_euler_step_top dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .particle (particle_ch),
    .result   (result_ch)
  );

  // clock
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // time limit
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // watch both channels
  always @(posedge clk) begin
    particle_t p;
    step_res_t a;
    if (!rst) begin
      if (particle_ch.valid && particle_ch.ready) begin
        p.loc = '{particle_ch.loc_x, particle_ch.loc_y, particle_ch.loc_z};
        p.vel = '{particle_ch.vel_x, particle_ch.vel_y, particle_ch.vel_z};
        p.acc = '{particle_ch.acc_x, particle_ch.acc_y, particle_ch.acc_z};
        p.age = particle_ch.age;
        p.age_rate = particle_ch.age_rate;
        p.substep = particle_ch.substep;
        board.note_particle(p);
      end
      if (result_ch.valid && result_ch.ready) begin
        a.loc = '{result_ch.new_loc_x, result_ch.new_loc_y, result_ch.new_loc_z};
        a.vel = '{result_ch.new_vel_x, result_ch.new_vel_y, result_ch.new_vel_z};
        a.acc = '{result_ch.new_acc_x, result_ch.new_acc_y, result_ch.new_acc_z};
        a.age = result_ch.new_age;
        a.alive = result_ch.alive;
        board.check_result(a);
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    result_ch.ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        result_ch.ready <= 0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        result_ch.ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= v;
    @(posedge clk);
    board.set_reg(idx, v);
  endtask

  // full attractor setup; narrow registers get random upper bits
  task automatic setup(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                       logic [31:0] rad, logic [31:0] g, logic lin,
                       logic [2:0] msk, logic en);
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_CENTRE_Z, cz);
    write_reg(REG_SOURCE_RADIUS, rad);
    write_reg(REG_SOURCE_GM, g);
    write_reg(REG_LINEAR_FALLOFF, {$urandom_range(0, 1) ? $urandom() : 32'd0} & ~32'd1 | lin);
    write_reg(REG_AXIS_MASK, {$urandom_range(0, 1) ? $urandom() : 32'd0} & ~32'd7 | msk);
    write_reg(REG_GRAVITY_ENABLE, {$urandom_range(0, 1) ? $urandom() : 32'd0} & ~32'd1 | en);
    wr_en <= 0;
    @(posedge clk);
  endtask

  task automatic send_particle(particle_t p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      particle_ch.valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    particle_ch.loc_x <= p.loc[0]; particle_ch.loc_y <= p.loc[1]; particle_ch.loc_z <= p.loc[2];
    particle_ch.vel_x <= p.vel[0]; particle_ch.vel_y <= p.vel[1]; particle_ch.vel_z <= p.vel[2];
    particle_ch.acc_x <= p.acc[0]; particle_ch.acc_y <= p.acc[1]; particle_ch.acc_z <= p.acc[2];
    particle_ch.age <= p.age;
    particle_ch.age_rate <= p.age_rate;
    particle_ch.substep <= p.substep;
    particle_ch.valid <= 1;
    do @(posedge clk); while (!particle_ch.ready);
  endtask

  task automatic drain();
    particle_ch.valid <= 0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic particle_t make_particle(
      logic signed [31:0] lx, logic signed [31:0] ly, logic signed [31:0] lz,
      logic signed [31:0] v, logic signed [31:0] a,
      logic [16:0] ag, logic [31:0] rate, logic [16:0] st);
    particle_t p;
    p.loc = '{lx, ly, lz};
    p.vel = '{v, -v, v >>> 3};
    p.acc = '{a, a >>> 5, -a};
    p.age = ag; p.age_rate = rate; p.substep = st;
    return p;
  endfunction

  // mostly live particles scattered around the attractor at many scales
  function automatic particle_t rand_particle();
    particle_t p;
    int        sh;
    for (int j = 0; j < 3; j++) begin
      sh = $urandom_range(0, 31);
      if ($urandom_range(0, 7) == 0) p.loc[j] = $urandom();
      else p.loc[j] = board.centre[j] + ($signed(32'($urandom())) >>> sh);
      p.vel[j] = $signed(32'($urandom())) >>> $urandom_range(0, 31);
      p.acc[j] = $signed(32'($urandom())) >>> $urandom_range(0, 31);
    end
    case ($urandom_range(0, 9))
      0: p.age = $urandom();
      1: p.age = AGE_ONE;
      default: p.age = $urandom_range(0, 60000);
    endcase
    p.age_rate = $urandom() >> $urandom_range(0, 32);
    if ($urandom_range(0, 4) == 0) p.substep = $urandom();
    else p.substep = $urandom_range(0, 65536) >> $urandom_range(0, 16);
    return p;
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_particle(rand_particle());
  endtask

  initial begin
    particle_ch.valid = 0;
    particle_ch.loc_x = 0; particle_ch.loc_y = 0; particle_ch.loc_z = 0;
    particle_ch.vel_x = 0; particle_ch.vel_y = 0; particle_ch.vel_z = 0;
    particle_ch.acc_x = 0; particle_ch.acc_y = 0; particle_ch.acc_z = 0;
    particle_ch.age = 0; particle_ch.age_rate = 0; particle_ch.substep = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset setup, gravity off: saturation extremes and plain integration
    send_particle(make_particle(FIX_MAX, FIX_MIN, 0, FIX_MAX, FIX_MAX, 0, 0, 17'd65536));
    send_particle(make_particle(FIX_MIN, FIX_MAX, -1, FIX_MIN, FIX_MIN, 0, 0, 17'd65536));
    send_particle(make_particle(32'sd100, 32'sd5, 32'sd7, 32'sd65536, -32'sd3, 100, 1, 0));
    send_random(40);
    drain();

    // unit attractor at the origin
    setup(0, 0, 0, 32'd65536, 32'd65536, 0, 3'd7, 1);
    // particle at the centre, and just inside and outside the near-centre limit
    send_particle(make_particle(0, 0, 0, 0, 32'sd1000, 0, 0, 17'd65536));
    send_particle(make_particle(1, 0, 0, 0, 32'sd1000, 0, 0, 17'd65536));
    send_particle(make_particle(66, 0, 0, 0, 32'sd1000, 0, 0, 17'd65536));
    // inside the radius and outside it
    send_particle(make_particle(32'sd32768, 0, 0, 32'sd10, 0, 0, 0, 17'd32768));
    send_particle(make_particle(32'sd196608, -32'sd131072, 32'sd65536, 0, 0, 0, 0, 17'd4096));
    send_particle(make_particle(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MAX, 0, 0, 0, 17'd65536));
    // lifetime: exactly 1.0 lives, just above dies, out-of-range age dies
    send_particle(make_particle(32'sd65536, 0, 0, 1, 1, 17'd65536, 0, 17'd65536));
    send_particle(make_particle(32'sd65536, 0, 0, 1, 1, 17'd65536, 1, 17'd65536));
    send_particle(make_particle(32'sd65536, 0, 0, 1, 1, 17'h1FFFF, 0, 0));
    send_particle(make_particle(32'sd65536, 0, 0, 1, 1, 0, 32'hFFFF_FFFF, 17'h1FFFF));
    send_particle(make_particle(32'sd65536, 32'sd3, 0, 1, 1, 0, 32'hFFFF_FFFF, 0));
    send_random(110);
    drain();

    // linear falloff, some axes, receiver holds off while particles keep coming
    setup($urandom(), $urandom(), $urandom(), 32'd131072, 32'd262144, 1, 3'd5, 1);
    hold_req = 1;
    send_random(120);
    drain();

    // extreme centre, zero radius, largest gm
    setup(FIX_MAX, FIX_MIN, 0, 0, 32'hFFFF_FFFF, 0, 3'd7, 1);
    send_random(110);
    drain();

    // largest radius, every particle inside
    setup($urandom(), $urandom(), $urandom(), 32'hFFFF_FFFF, $urandom() >> 8, 1, 3'd3, 1);
    send_random(110);
    drain();

    // random setup with gravity off
    setup($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(0, 1),
          $urandom_range(0, 7), 0);
    send_random(90);
    drain();

    setup($urandom() >>> 8, $urandom() >>> 8, $urandom() >>> 8, $urandom() >> 12,
          $urandom() >> $urandom_range(0, 20), 0, $urandom_range(0, 7), 1);
    send_random(110);
    drain();

    // closing part without idling on either side
    setup($urandom(), $urandom(), $urandom(), $urandom() >> $urandom_range(0, 24),
          $urandom(), $urandom_range(0, 1), 3'd6, 1);
    quiet = 1;
    send_random(110);
    drain();

    if (board.mismatches == 0 && board.waiting() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
